### src/rsparse_pkg.sv
// Package for the radix sparse table: default sizes and the sequencer state type.
// Used by rsparse_ram and radix_sparse_table; depends on nothing else.
package rsparse_pkg;

    localparam int DefDigitBits = 8;
    localparam int DefLevels    = 4;
    localparam int DefNodePool  = 256;
    localparam int DefValueBits = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_WRITE,
        ST_RESP
    } seq_state_t;

endpackage

### src/radix_sparse_table.sv
// Top level of the radix sparse table: sequencer, allocator and output register.
// Depends on rsparse_pkg and instantiates rsparse_ram for the node pool.
//
// This block keeps a sparse map from a 32-bit key to a value as a radix tree of
// LEVELS levels, each node holding 2^DIGIT_BITS entries, in a pool of NODE_POOL
// nodes held in one single-port memory. The key is consumed DIGIT_BITS bits at a
// time from the top. A lookup (op 0) walks the inner levels and returns the leaf
// value with found set when it is nonzero, or zero with found clear when a child
// is missing. A store (op 1) walks the existing path, counts how many fresh nodes
// it needs, and either sets pool_full and changes nothing, or takes nodes from a
// bump allocator and finally writes the value into the leaf. Every item gives
// exactly one result item. One item is worked on at a time: each memory read
// is an address step (ST_WALK) followed by a check of the registered data
// (ST_CHECK), and each write is a step of its own (ST_WRITE), all through the
// single memory port. in_stall stays high while an item is in progress. A
// finished result sits in the output register, and the block already takes
// the next item while that result waits to be taken. After reset the memory
// is swept to zero, one entry per cycle, over all NODE_POOL*2^DIGIT_BITS entries
// (65536 at the default sizes); in_stall is high during that sweep.
module radix_sparse_table
    import rsparse_pkg::*;
#(
    parameter int DIGIT_BITS = DefDigitBits,
    parameter int LEVELS     = DefLevels,
    parameter int NODE_POOL  = DefNodePool,
    parameter int VALUE_BITS = DefValueBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] key,
    input  logic [31:0] store_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_value,
    output logic        found,
    output logic        pool_full
);

    localparam int FANOUT     = 1 << DIGIT_BITS;
    localparam int DEPTH      = NODE_POOL * FANOUT;
    localparam int NODE_BITS  = $clog2(NODE_POOL);
    localparam int CNT_BITS   = $clog2(NODE_POOL + 1);
    localparam int ADDR_BITS  = NODE_BITS + DIGIT_BITS;
    localparam int ENTRY_BITS = (VALUE_BITS > NODE_BITS) ? VALUE_BITS : NODE_BITS;
    localparam int KEY_SPAN   = LEVELS * DIGIT_BITS;
    localparam int LVL_BITS   = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int CMP_BITS   = ((CNT_BITS > LVL_BITS) ? CNT_BITS : LVL_BITS) + 1;

    localparam logic [LVL_BITS-1:0]  LvlLast   = LVL_BITS'(LEVELS - 1);
    localparam logic [ADDR_BITS-1:0] AddrLast  = ADDR_BITS'(DEPTH - 1);
    localparam logic [CMP_BITS-1:0]  CmpLast   = CMP_BITS'(LEVELS - 1);
    localparam logic [CMP_BITS-1:0]  CmpPool   = CMP_BITS'(NODE_POOL);

    seq_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]  clear_addr_reg, clear_addr_next;
    logic [CNT_BITS-1:0]   next_free_reg, next_free_next;
    logic                  op_reg, op_next;
    logic [KEY_SPAN-1:0]   key_sh_reg, key_sh_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    logic [LVL_BITS-1:0]   lvl_reg, lvl_next;
    logic [31:0]           res_value_reg, res_value_next;
    logic                  res_found_reg, res_found_next;
    logic                  res_full_reg, res_full_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_value_reg, out_value_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_full_reg, out_full_next;

    logic                  in_take;
    logic                  out_free;
    logic [KEY_SPAN+31:0]  key_wide;
    logic [VALUE_BITS+31:0] value_wide;
    logic [DIGIT_BITS-1:0] digit;
    logic [KEY_SPAN-1:0]   key_shifted;
    logic                  entry_nonzero;
    logic [ENTRY_BITS+31:0] entry_wide;
    logic [CMP_BITS-1:0]   needed;
    logic [CMP_BITS-1:0]   remain;
    logic [ENTRY_BITS+VALUE_BITS-1:0] val_entry_wide;
    logic [ENTRY_BITS+NODE_BITS-1:0]  ptr_entry_wide;

    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [ENTRY_BITS-1:0] mem_wdata;
    logic [ENTRY_BITS-1:0] mem_rdata;

    rsparse_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Key bits above the tree's span are dropped; a span wider than the key
    // fills the top digits with zeros.
    assign key_wide    = {{KEY_SPAN{1'b0}}, key};
    assign value_wide  = {{VALUE_BITS{1'b0}}, store_value};
    assign digit       = key_sh_reg[KEY_SPAN-1 -: DIGIT_BITS];
    assign key_shifted = {key_sh_reg[KEY_SPAN-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};

    assign entry_nonzero  = |mem_rdata;
    assign entry_wide     = {32'd0, mem_rdata};
    assign val_entry_wide = {{ENTRY_BITS{1'b0}}, value_reg};
    assign ptr_entry_wide = {{ENTRY_BITS{1'b0}}, next_free_reg[NODE_BITS-1:0]};

    // Nodes a store still needs against nodes left in the pool.
    assign needed = CmpLast - CMP_BITS'(lvl_reg);
    assign remain = CmpPool - CMP_BITS'(next_free_reg);

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == AddrLast)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (lvl_reg == LvlLast)
                begin
                    state_next = ST_RESP;
                end
                else if (entry_nonzero)
                begin
                    if (op_reg && (lvl_reg + 1'b1 == LvlLast))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
                else if (!op_reg || (needed > remain))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (lvl_reg == LvlLast)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {node_reg, digit};
        mem_wdata = val_entry_wide[ENTRY_BITS-1:0];
        in_stall  = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clear_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_WALK:
            begin
                mem_re = 1'b1;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (lvl_reg != LvlLast)
                begin
                    mem_wdata = ptr_entry_wide[ENTRY_BITS-1:0];
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        next_free_next  = next_free_reg;
        op_next         = op_reg;
        key_sh_next     = key_sh_reg;
        value_next      = value_reg;
        node_next       = node_reg;
        lvl_next        = lvl_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_full_next   = out_full_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next        = op;
                    key_sh_next    = key_wide[KEY_SPAN-1:0];
                    value_next     = value_wide[VALUE_BITS-1:0];
                    node_next      = '0;
                    lvl_next       = '0;
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                end
            end
            ST_CHECK:
            begin
                if (lvl_reg == LvlLast)
                begin
                    // Leaf entry of a lookup.
                    res_value_next = entry_wide[31:0];
                    res_found_next = entry_nonzero;
                end
                else if (entry_nonzero)
                begin
                    node_next   = mem_rdata[NODE_BITS-1:0];
                    lvl_next    = lvl_reg + 1'b1;
                    key_sh_next = key_shifted;
                end
                else if (op_reg && (needed > remain))
                begin
                    res_full_next = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (lvl_reg != LvlLast)
                begin
                    node_next      = next_free_reg[NODE_BITS-1:0];
                    next_free_next = next_free_reg + 1'b1;
                    lvl_next       = lvl_reg + 1'b1;
                    key_sh_next    = key_shifted;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_found_next = res_found_reg;
                    out_full_next  = res_full_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            next_free_reg  <= CNT_BITS'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            next_free_reg  <= next_free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_sh_reg    <= key_sh_next;
        value_reg     <= value_next;
        node_reg      <= node_next;
        lvl_reg       <= lvl_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign found      = out_found_reg;
    assign pool_full  = out_full_reg;

endmodule

### src/rsparse_ram.sv
// Single-port node pool memory with a registered read port.
// Sized by its parameters; uses no package items beyond the shared defaults.
module rsparse_ram
    import rsparse_pkg::*;
#(
    parameter int DEPTH     = DefNodePool * (1 << DefDigitBits),
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = DefValueBits
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
